// File: design/unsigned_64bit_divider_top_assert.svh
// ----------------------------------------------------------------------------
// divider assertion macros
// immediate-style wrappers for concurrent checks, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_64BIT_DIVIDER_TOP_ASSERT_SVH
`define UNSIGNED_64BIT_DIVIDER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during rst
`define U64DIV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u64div check failed");

// next-cycle implication, sampled on clk, off during rst
`define U64DIV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u64div check failed");

`else

`define U64DIV_ASSERT_IMPL(lbl, ante, cons)
`define U64DIV_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: design/u64div_pkg.sv
// ----------------------------------------------------------------------------
// u64div_pkg
// shared widths and defaults for the pipelined restoring divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u64div_pkg;

  localparam int FIELD_WIDTH        = 64;
  localparam int DATA_WIDTH_DEFAULT = 64;
  localparam int DATA_WIDTH_MIN     = 8;

endpackage

// File: design/u64div_op_if.sv
// ----------------------------------------------------------------------------
// u64div_op_if
// operand channel: dividend and divisor with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u64div_op_if
  import u64div_pkg::*;
();

  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] dividend;
  logic [FIELD_WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);

endinterface

// File: design/u64div_res_if.sv
// ----------------------------------------------------------------------------
// u64div_res_if
// result channel: quotient with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u64div_res_if
  import u64div_pkg::*;
();

  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] quotient;

  modport source (output valid, output quotient, input ready);
  modport sink   (input valid, input quotient, output ready);

endinterface

// File: design/u64div_stage.sv
// ----------------------------------------------------------------------------
// u64div_stage
// one restoring step: shift in a dividend bit, trial subtract, register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u64div_stage #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_rem,
  input  logic [WIDTH-1:0] in_num,
  input  logic [WIDTH-1:0] in_quo,
  input  logic [WIDTH-1:0] in_den,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_rem,
  output logic [WIDTH-1:0] out_num,
  output logic [WIDTH-1:0] out_quo,
  output logic [WIDTH-1:0] out_den
);

  logic             carry;
  logic [WIDTH-1:0] shifted;
  logic             take;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] quo_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    carry    = in_rem[WIDTH-1];
    shifted  = {in_rem[WIDTH-2:0], in_num[WIDTH-1]};
    take     = carry || (shifted >= in_den);
    rem_next = take ? (shifted - in_den) : shifted;
    quo_next = {in_quo[WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rem <= rem_next;
      out_num <= {in_num[WIDTH-2:0], 1'b0};
      out_quo <= quo_next;
      out_den <= in_den;
    end
  end

endmodule

// File: design/unsigned_64bit_divider_top.sv
// ----------------------------------------------------------------------------
// unsigned_64bit_divider_top
// pipelined unsigned restoring divider, one quotient bit per stage
//
//   channel   dir   payload               handshake
//   operands  in    dividend, divisor     valid/ready
//   result    out   quotient              valid/ready
//
// one register stage per quotient bit;
// a new operand pair enters every cycle while no stage is stalled
// each stage holds its item while the next one is full and stalled, and
// bubbles close up; stage valids clear on synchronous rst
// a zero divisor gives an all-ones quotient in DATA_WIDTH bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "unsigned_64bit_divider_top_assert.svh"

module unsigned_64bit_divider_top
  import u64div_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  u64div_op_if.sink   operands,
  u64div_res_if.source result
);

  localparam int W = DATA_WIDTH;

  logic         valid [0:W];
  logic         ready [0:W];
  logic [W-1:0] rem   [0:W];
  logic [W-1:0] num   [0:W];
  logic [W-1:0] quo   [0:W];
  logic [W-1:0] den   [0:W];

  assign valid[0]       = operands.valid;
  assign operands.ready = ready[0];
  assign rem[0]         = '0;
  assign num[0]         = operands.dividend[W-1:0];
  assign quo[0]         = '0;
  assign den[0]         = operands.divisor[W-1:0];

  for (genvar i = 0; i < W; i++) begin : g_stage
    u64div_stage #(
      .WIDTH(W)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid[i]),
      .in_ready (ready[i]),
      .in_rem   (rem[i]),
      .in_num   (num[i]),
      .in_quo   (quo[i]),
      .in_den   (den[i]),
      .out_valid(valid[i+1]),
      .out_ready(ready[i+1]),
      .out_rem  (rem[i+1]),
      .out_num  (num[i+1]),
      .out_quo  (quo[i+1]),
      .out_den  (den[i+1])
    );
  end

  assign result.valid    = valid[W];
  assign ready[W]        = result.ready;
  assign result.quotient = FIELD_WIDTH'(quo[W]);

  `U64DIV_ASSERT_NEXT(a_enter_first_stage, operands.valid && operands.ready, valid[1])
  `U64DIV_ASSERT_IMPL(a_drain_frees_input, result.ready, operands.ready)
  `U64DIV_ASSERT_IMPL(a_zero_divisor_ones, result.valid && (den[W] == '0), quo[W] == '1)

endmodule
